// ===== design/sqvs_pkg.sv =====
// Shared types and constants for the sprite quad vertex setup block.
// No dependencies; sqvs_rot_stage and the top level import it.
package sqvs_pkg;

	// Angle field width that the rotation honors (upper bits ignored)
	localparam int AngleBits   = 16;
	localparam int CordicSteps = 20;
	localparam int DivSteps    = 16;
	localparam int VecPrescale = 14;
	localparam logic [20:0] CordicGain = 21'd636751;

	// Arctangent per step, units of 2^-32 turn
	localparam logic [31:0] ATAN_TURN [0:CordicSteps-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331, 32'd21354465, 32'd10680862, 32'd5340245,
		32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
		32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304
	};

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_TEX_W    = 3'd0,
		REG_TEX_H    = 3'd1,
		REG_ORIGIN_X = 3'd2,
		REG_ORIGIN_Y = 3'd3,
		REG_PIVOT_X  = 3'd4,
		REG_PIVOT_Y  = 3'd5
	} reg_idx_t;

	localparam logic [1:0] LastCorner = 2'd3;

	typedef struct packed {
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic [14:0]        dest_w;
		logic [14:0]        dest_h;
		logic [14:0]        src_x;
		logic [14:0]        src_y;
		logic [14:0]        src_w;
		logic [14:0]        src_h;
		logic [15:0]        angle;
	} sprite_t;

	typedef struct packed {
		logic [1:0]         corner;
		logic signed [15:0] vert_x;
		logic signed [15:0] vert_y;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic               last;
	} vertex_t;

	// Divider state for one texture coordinate
	typedef struct packed {
		logic [14:0] rem;
		logic [15:0] quo;
		logic [15:0] bits;
		logic        sat;
		logic        zero;
	} div_t;

	// Per-corner pipeline payload
	typedef struct packed {
		logic [1:0]         corner;
		logic               rot;
		logic signed [34:0] x;
		logic signed [34:0] y;
		logic signed [32:0] z;
		logic signed [17:0] base_x;
		logic signed [17:0] base_y;
		div_t               du;
		div_t               dv;
	} pipe_t;

endpackage

// ===== design/sqvs_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct.
// Depends on nothing; payload type is a parameter.
interface sqvs_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/sqvs_rot_stage.sv =====
// One pipeline stage: a CORDIC step plus an optional restoring divide step.
// Depends on sqvs_pkg.
module sqvs_rot_stage #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [14:0]    tex_w,
	input  logic [14:0]    tex_h,
	input  logic           in_valid,
	input  sqvs_pkg::pipe_t in_data,
	output logic           out_valid,
	output sqvs_pkg::pipe_t out_data
);
	import sqvs_pkg::*;

	pipe_t nxt;

	function automatic div_t div_step(div_t d, logic [14:0] size);
		logic [15:0] r2;
		div_t o;
		r2 = {d.rem, d.bits[15]};
		o = d;
		o.bits = {d.bits[14:0], 1'b0};
		if (r2 >= {1'b0, size}) begin
			o.rem = 15'(r2 - {1'b0, size});
			o.quo = {d.quo[14:0], 1'b1};
		end else begin
			o.rem = r2[14:0];
			o.quo = {d.quo[14:0], 1'b0};
		end
		return o;
	endfunction

	// Micro-rotation toward zero residual angle
	always_comb begin
		logic signed [34:0] xs;
		logic signed [34:0] ys;
		logic signed [32:0] at;
		xs = in_data.x >>> STEP;
		ys = in_data.y >>> STEP;
		at = $signed({1'b0, ATAN_TURN[STEP]});
		nxt = in_data;
		if (!in_data.z[32]) begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - at;
		end else begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + at;
		end
		if (STEP < DivSteps) begin
			nxt.du = div_step(in_data.du, tex_w);
			nxt.dv = div_step(in_data.dv, tex_h);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

// ===== design/sprite_quad_vertex_setup.sv =====
// Sprite quad vertex setup: four corner vertices per sprite, optional rotation.
// A corner sequencer issues one corner per cycle, unless the output is stalled,
// into a 23-stage pipeline (20 CORDIC steps); corners leave in order.
// A new sprite is taken as the last corner of the previous one is issued.
// Reset: arst_n clears config registers to 0 and all valid bits.
// Depends on sqvs_pkg, sqvs_stream_if, sqvs_rot_stage.
module sprite_quad_vertex_setup (
	input  logic        clk,
	input  logic        arst_n,
	sqvs_stream_if.sink   sprite,
	sqvs_stream_if.source vertex,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	import sqvs_pkg::*;

	logic [14:0]        tex_w_q, tex_h_q;
	logic signed [15:0] org_x_q, org_y_q, piv_x_q, piv_y_q;

	logic    en;
	sprite_t item_q;
	logic    busy_q;
	logic [1:0] cnt_q;

	logic    v_s1;
	pipe_t   p_s1;
	logic    v_c [0:CordicSteps];
	pipe_t   p_c [0:CordicSteps];
	logic    v_s22;
	pipe_t   p_s22;
	logic signed [55:0] mx_s22, my_s22;
	logic    out_valid_q;
	vertex_t out_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q <= '0; tex_h_q <= '0;
			org_x_q <= '0; org_y_q <= '0;
			piv_x_q <= '0; piv_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEX_W:    tex_w_q <= cfg_wdata[14:0];
				REG_TEX_H:    tex_h_q <= cfg_wdata[14:0];
				REG_ORIGIN_X: org_x_q <= $signed(cfg_wdata);
				REG_ORIGIN_Y: org_y_q <= $signed(cfg_wdata);
				REG_PIVOT_X:  piv_x_q <= $signed(cfg_wdata);
				REG_PIVOT_Y:  piv_y_q <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Whole pipeline advances unless the output register is stuck
	assign en = !out_valid_q || vertex.ready;
	assign sprite.ready = en && (!busy_q || cnt_q == LastCorner);

	// Corner sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (sprite.valid && sprite.ready) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (en && busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == LastCorner) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sprite.valid && sprite.ready) begin
			item_q <= sprite.data;
		end
	end

	// Stage 1: corner offsets, quadrant turn, divider setup
	pipe_t s1_nxt;
	always_comb begin
		logic               right, bottom;
		logic [15:0]        ang;
		logic [31:0]        a32, asum, z32;
		logic [1:0]         q;
		logic signed [17:0] ox, oy, dvx, dvy, bx;
		logic signed [17:0] by;
		logic signed [34:0] vx, vy;
		logic [15:0]        ue, ve;
		right  = cnt_q[1];
		bottom = !cnt_q[0];
		ang    = item_q.angle & 16'((64'd1 << AngleBits) - 64'd1);
		a32    = 32'({16'd0, ang} << (32 - AngleBits));
		asum   = a32 + 32'h2000_0000;
		q      = asum[31:30];
		z32    = a32 - {q, 30'd0};
		ox = right ? $signed({3'd0, item_q.dest_w}) : 18'sd0;
		oy = bottom ? $signed({3'd0, item_q.dest_h}) : 18'sd0;
		dvx = ox - 18'(piv_x_q);
		dvy = oy - 18'(piv_y_q);
		bx  = 18'(item_q.dest_x) - 18'(org_x_q);
		by  = 18'(item_q.dest_y) - 18'(org_y_q);
		vx  = 35'(dvx) <<< VecPrescale;
		vy  = 35'(dvy) <<< VecPrescale;
		ue  = right ? 16'(item_q.src_x) + 16'(item_q.src_w) : 16'(item_q.src_x);
		ve  = bottom ? 16'(item_q.src_y) + 16'(item_q.src_h) : 16'(item_q.src_y);

		s1_nxt.corner = cnt_q;
		s1_nxt.rot    = (ang != 16'd0);
		unique case (q)
			2'd1: begin s1_nxt.x = -vy; s1_nxt.y = vx; end
			2'd2: begin s1_nxt.x = -vx; s1_nxt.y = -vy; end
			2'd3: begin s1_nxt.x = vy; s1_nxt.y = -vx; end
			default: begin s1_nxt.x = vx; s1_nxt.y = vy; end
		endcase
		s1_nxt.z = 33'($signed(z32));
		if (ang != 16'd0) begin
			s1_nxt.base_x = bx + 18'(piv_x_q);
			s1_nxt.base_y = by + 18'(piv_y_q);
		end else begin
			s1_nxt.base_x = bx + ox;
			s1_nxt.base_y = by + oy;
		end
		s1_nxt.du.rem  = {1'b0, ue[15:2]};
		s1_nxt.du.quo  = '0;
		s1_nxt.du.bits = {ue[1:0], 14'd0};
		s1_nxt.du.sat  = {1'b0, ue} >= {tex_w_q, 2'b00};
		s1_nxt.du.zero = (tex_w_q == '0);
		s1_nxt.dv.rem  = {1'b0, ve[15:2]};
		s1_nxt.dv.quo  = '0;
		s1_nxt.dv.bits = {ve[1:0], 14'd0};
		s1_nxt.dv.sat  = {1'b0, ve} >= {tex_h_q, 2'b00};
		s1_nxt.dv.zero = (tex_h_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= s1_nxt;
		end
	end

	// CORDIC and divider steps
	assign v_c[0] = v_s1;
	assign p_c[0] = p_s1;
	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		sqvs_rot_stage #(.STEP(i)) u_stage (
			.clk(clk), .arst_n(arst_n), .en(en),
			.tex_w(tex_w_q), .tex_h(tex_h_q),
			.in_valid(v_c[i]), .in_data(p_c[i]),
			.out_valid(v_c[i+1]), .out_data(p_c[i+1])
		);
	end

	// Gain multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s22 <= 1'b0;
		end else if (en) begin
			v_s22 <= v_c[CordicSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s22  <= p_c[CordicSteps];
			mx_s22 <= 56'(p_c[CordicSteps].x) * 56'($signed({1'b0, CordicGain}));
			my_s22 <= 56'(p_c[CordicSteps].y) * 56'($signed({1'b0, CordicGain}));
		end
	end

	// Round, add pivot base, saturate; pick UV
	vertex_t out_nxt;
	always_comb begin
		logic signed [55:0] rxw, ryw;
		logic signed [22:0] sx, sy;
		rxw = (mx_s22 + (56'sd1 <<< 33)) >>> 34;
		ryw = (my_s22 + (56'sd1 <<< 33)) >>> 34;
		sx = 23'(p_s22.base_x) + (p_s22.rot ? 23'(rxw) : 23'sd0);
		sy = 23'(p_s22.base_y) + (p_s22.rot ? 23'(ryw) : 23'sd0);
		out_nxt.corner = p_s22.corner;
		out_nxt.last   = (p_s22.corner == LastCorner);
		priority if (sx > 23'sd32767) out_nxt.vert_x = 16'sh7FFF;
		else if (sx < -23'sd32768)    out_nxt.vert_x = 16'sh8000;
		else                          out_nxt.vert_x = 16'(sx);
		priority if (sy > 23'sd32767) out_nxt.vert_y = 16'sh7FFF;
		else if (sy < -23'sd32768)    out_nxt.vert_y = 16'sh8000;
		else                          out_nxt.vert_y = 16'(sy);
		priority if (p_s22.du.zero) out_nxt.tex_u = '0;
		else if (p_s22.du.sat)      out_nxt.tex_u = 16'hFFFF;
		else                        out_nxt.tex_u = p_s22.du.quo;
		priority if (p_s22.dv.zero) out_nxt.tex_v = '0;
		else if (p_s22.dv.sat)      out_nxt.tex_v = 16'hFFFF;
		else                        out_nxt.tex_v = p_s22.dv.quo;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= out_nxt;
		end
	end

	assign vertex.valid = out_valid_q;
	assign vertex.data  = out_q;

	// Checks
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last == (out_q.corner == LastCorner)))
		else $error("last flag does not match corner");
	a_seq_start: assert property (@(posedge clk) disable iff (!arst_n)
		(sprite.valid && sprite.ready) |=> (busy_q && cnt_q == 2'd0))
		else $error("sequencer did not start at first corner");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != LastCorner) |-> !sprite.ready)
		else $error("new sprite taken mid-quad");

endmodule
